>>> sv/upd_pkg.sv
// shared types, character constants and hex helpers for the url percent decoder
// used by upd_front, upd_queue, upd_back and url_percent_decoder; no dependencies
package upd_pkg;

    // escape tracking, one-hot
    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,   // no escape open
        PH_C1   = 6'b000010,   // waiting for first digit
        PH_C2   = 6'b000100,   // waiting for second digit
        PH_MID  = 6'b001000,   // two-byte: separator character
        PH_D1   = 6'b010000,   // two-byte: first digit of second pair
        PH_D2   = 6'b100000    // two-byte: second digit of second pair
    } t_phase;

    // result status codes
    typedef enum logic [1:0] {
        ST_BYTE     = 2'd0,
        ST_NEED     = 2'd1,
        ST_BAD_HEX  = 2'd2,
        ST_NO_UTF8  = 2'd3
    } t_status;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] C_CHAR     = 8'h43;
    localparam logic [7:0] TWO_CHAR   = 8'h32;
    localparam logic [7:0] THREE_CHAR = 8'h33;
    localparam logic [7:0] FOLD_BITS  = 8'h40;

    // classified request handed from front to back
    typedef struct packed {
        logic       is_hex;   // hi/lo are hex digits to combine
        logic [7:0] hi;
        logic [7:0] lo;       // plain character when not hex
        logic       fold;     // or in the fold bits
        t_status    status;
        logic       last;
    } t_req;

    function automatic logic hex_ok(input logic [7:0] c);
        hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
              || (c >= 8'h61 && c <= 8'h66);
    endfunction

    // value of a digit already known to be hex
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c[6]) begin
            hex_val = c[3:0] + 4'd9;
        end else begin
            hex_val = c[3:0];
        end
    endfunction

endpackage

>>> sv/upd_front.sv
// front end: accepts characters, tracks escapes and classifies each result
// depends on upd_pkg
module upd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_lazy,
    input  logic          i_in_valid,
    input  logic [7:0]    i_in_char,
    input  logic          i_in_last,
    input  logic          i_full,
    output logic          o_push,
    output upd_pkg::t_req o_req
);

    upd_pkg::t_phase r_phase, n_phase;
    logic            r_skip, n_skip;
    logic [7:0]      r_h0, n_h0;
    logic [7:0]      r_h1, n_h1;
    logic [7:0]      r_h2, n_h2;

    logic            accept;
    logic            err;
    upd_pkg::t_status err_st;

    assign accept = i_in_valid && !i_full;

    always_comb begin
        n_phase     = r_phase;
        n_skip      = r_skip;
        n_h0        = r_h0;
        n_h1        = r_h1;
        n_h2        = r_h2;
        err         = 1'b0;
        err_st      = upd_pkg::ST_NEED;
        o_push      = 1'b0;
        o_req.is_hex = 1'b0;
        o_req.hi    = r_h0;
        o_req.lo    = i_in_char;
        o_req.fold  = 1'b0;
        o_req.status = upd_pkg::ST_BYTE;
        o_req.last  = i_in_last;

        if (accept) begin
            if (r_skip) begin
                if (i_in_last) begin
                    n_skip = 1'b0;
                end
            end else begin
                case (r_phase)
                    upd_pkg::PH_C1: begin
                        n_h0 = i_in_char;
                        if (i_in_last) begin
                            err = 1'b1;
                        end else begin
                            n_phase = upd_pkg::PH_C2;
                        end
                    end
                    upd_pkg::PH_C2: begin
                        n_h1 = i_in_char;
                        if (!i_lazy && r_h0 == upd_pkg::C_CHAR) begin
                            if (i_in_last) begin
                                err = 1'b1;
                            end else begin
                                n_phase = upd_pkg::PH_MID;
                            end
                        end else if (!(upd_pkg::hex_ok(r_h0) && upd_pkg::hex_ok(i_in_char))) begin
                            err    = 1'b1;
                            err_st = upd_pkg::ST_BAD_HEX;
                        end else begin
                            o_push       = 1'b1;
                            o_req.is_hex = 1'b1;
                            n_phase      = upd_pkg::PH_IDLE;
                        end
                    end
                    upd_pkg::PH_MID: begin
                        if (i_in_last) begin
                            err = 1'b1;
                        end else begin
                            n_phase = upd_pkg::PH_D1;
                        end
                    end
                    upd_pkg::PH_D1: begin
                        n_h2 = i_in_char;
                        if (i_in_last) begin
                            err = 1'b1;
                        end else begin
                            n_phase = upd_pkg::PH_D2;
                        end
                    end
                    upd_pkg::PH_D2: begin
                        o_req.hi = r_h2;
                        if (!(upd_pkg::hex_ok(r_h1) && upd_pkg::hex_ok(r_h2)
                              && upd_pkg::hex_ok(i_in_char))) begin
                            err    = 1'b1;
                            err_st = upd_pkg::ST_BAD_HEX;
                        end else if (r_h1 != upd_pkg::TWO_CHAR
                                     && r_h1 != upd_pkg::THREE_CHAR) begin
                            err    = 1'b1;
                            err_st = upd_pkg::ST_NO_UTF8;
                        end else begin
                            o_push       = 1'b1;
                            o_req.is_hex = 1'b1;
                            o_req.fold   = (r_h1 == upd_pkg::THREE_CHAR);
                            n_phase      = upd_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = upd_pkg::PH_IDLE;
                        if (i_in_char == upd_pkg::PCT_CHAR) begin
                            if (i_in_last) begin
                                err = 1'b1;
                            end else begin
                                n_phase = upd_pkg::PH_C1;
                            end
                        end else begin
                            o_push = 1'b1;
                        end
                    end
                endcase

                // an error ends the string and swallows the rest of it
                if (err) begin
                    o_push       = 1'b1;
                    o_req.is_hex = 1'b0;
                    o_req.status = err_st;
                    o_req.last   = 1'b1;
                    n_phase      = upd_pkg::PH_IDLE;
                    n_skip       = !i_in_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= upd_pkg::PH_IDLE;
            r_skip  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_skip  <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h0 <= n_h0;
        r_h1 <= n_h1;
        r_h2 <= n_h2;
    end

endmodule

>>> sv/upd_queue.sv
// short request queue between front and back
// depends on upd_pkg
module upd_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upd_pkg::t_req i_req,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output upd_pkg::t_req o_req
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    upd_pkg::t_req  r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_req   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

endmodule

>>> sv/upd_back.sv
// back end: builds the decoded byte and holds the result register
// depends on upd_pkg
module upd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  upd_pkg::t_req i_req,
    output logic          o_pop,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [7:0]    o_out_byte,
    output logic [1:0]    o_status,
    output logic          o_out_last
);

    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic [1:0] r_status;
    logic       r_last;

    assign o_pop = i_q_valid && (!r_valid || !i_out_stall);

    always_comb begin
        if (i_req.status != upd_pkg::ST_BYTE) begin
            n_byte = 8'h00;
        end else if (i_req.is_hex) begin
            n_byte = {upd_pkg::hex_val(i_req.hi), upd_pkg::hex_val(i_req.lo)};
            if (i_req.fold) begin
                n_byte = n_byte | upd_pkg::FOLD_BITS;
            end
        end else begin
            n_byte = i_req.lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte   <= n_byte;
            r_status <= i_req.status;
            r_last   <= i_req.last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_status    = r_status;
    assign o_out_last  = r_last;

endmodule

>>> sv/url_percent_decoder.sv
// url percent decoder: one character in per cycle while the queue is not full; an accepted
// character is registered in the request queue and then in the one-deep result register
// in the back; a result register stall backs up the queue
// synchronous active-low reset clears escape state, skip flag, queue and lazy_mode (0)
// top level; depends on upd_pkg, upd_front, upd_queue, upd_back
module url_percent_decoder #(
    parameter int QUEUE_DEPTH = 2    // request queue entries, 2 to 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_char,
    input  logic        i_in_last,
    // decoded result
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_out_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // register index as selected by the word address
    localparam logic REG_LAZY = 1'b0;

    logic          r_lazy;
    logic          q_full;
    logic          q_valid;
    logic          push;
    logic          pop;
    upd_pkg::t_req front_req;
    upd_pkg::t_req back_req;

    // lazy_mode register, written on the access phase
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lazy <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_LAZY) begin
            r_lazy <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_LAZY) ? {31'd0, r_lazy} : 32'd0;

    // input stalls only when the queue is full
    assign o_in_stall = q_full;

    // front: escape tracking and error classification, one character per cycle while the queue is not full
    upd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lazy     (r_lazy),
        .i_in_valid (i_in_valid),
        .i_in_char  (i_in_char),
        .i_in_last  (i_in_last),
        .i_full     (q_full),
        .o_push     (push),
        .o_req      (front_req)
    );

    // queue decouples the front from output back-pressure
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_req   (back_req)
    );

    // back: hex combine, fold for the two-byte form, result register
    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_req       (back_req),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_out_last  (o_out_last)
    );

endmodule

>>> tb/upd_checker.sv
// result checker for the url percent decoder: tracks config writes, predicts decoded results
// for each accepted request and compares them with the output channel; depends on upd_pkg
`timescale 1ns / 100ps

module upd_checker #(
    parameter logic [2:0] LAZY_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_char,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic [1:0]  i_status,
    input  logic        i_out_last,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0]       data;
        upd_pkg::t_status status;
        logic             last;
    } t_decoded;

    t_decoded   decoded_q[$];
    int         mismatch_count = 0;

    // predictor state
    upd_pkg::t_phase esc_phase;
    logic            two_byte;
    logic [7:0]      held [4];
    logic            skipping;
    logic            lazy;

    function automatic bit digit_value(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - 8'h30);
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            v = 4'(c - 8'h41 + 8'd10);
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            v = 4'(c - 8'h61 + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic add_decoded(input logic [7:0] data, input upd_pkg::t_status status,
                               input logic last);
        t_decoded e;
        e.data   = data;
        e.status = status;
        e.last   = last;
        decoded_q.insert(decoded_q.size(), e);
    endtask

    // error closes the string; skip the rest unless this was its last char
    task automatic abort_string(input upd_pkg::t_status status, input logic last);
        esc_phase = upd_pkg::PH_IDLE;
        two_byte  = 1'b0;
        skipping  = !last;
        add_decoded(8'h00, status, 1'b1);
    endtask

    task automatic decode_char(input logic [7:0] c, input logic last);
        logic [3:0] hi, lo, sel;
        bit         hi_ok, lo_ok, sel_ok;
        logic [7:0] v;
        if (skipping) begin
            if (last) begin
                skipping = 1'b0;
            end
            return;
        end
        case (esc_phase)
            upd_pkg::PH_C1: begin
                held[0] = c;
                if (last) begin
                    abort_string(upd_pkg::ST_NEED, last);
                end else begin
                    esc_phase = upd_pkg::PH_C2;
                end
            end
            upd_pkg::PH_C2: begin
                held[1] = c;
                // mode is sampled here
                two_byte = !lazy && held[0] == upd_pkg::C_CHAR;
                if (two_byte) begin
                    if (last) begin
                        abort_string(upd_pkg::ST_NEED, last);
                    end else begin
                        esc_phase = upd_pkg::PH_MID;
                    end
                end else begin
                    hi_ok = digit_value(held[0], hi);
                    lo_ok = digit_value(held[1], lo);
                    if (!(hi_ok && lo_ok)) begin
                        abort_string(upd_pkg::ST_BAD_HEX, last);
                    end else begin
                        esc_phase = upd_pkg::PH_IDLE;
                        add_decoded({hi, lo}, upd_pkg::ST_BYTE, last);
                    end
                end
            end
            upd_pkg::PH_MID: begin
                // separator is not checked
                if (last) begin
                    abort_string(upd_pkg::ST_NEED, last);
                end else begin
                    esc_phase = upd_pkg::PH_D1;
                end
            end
            upd_pkg::PH_D1: begin
                held[2] = c;
                if (last) begin
                    abort_string(upd_pkg::ST_NEED, last);
                end else begin
                    esc_phase = upd_pkg::PH_D2;
                end
            end
            upd_pkg::PH_D2: begin
                held[3] = c;
                sel_ok = digit_value(held[1], sel);
                hi_ok  = digit_value(held[2], hi);
                lo_ok  = digit_value(held[3], lo);
                if (!(sel_ok && hi_ok && lo_ok)) begin
                    abort_string(upd_pkg::ST_BAD_HEX, last);
                end else if (held[1] != upd_pkg::TWO_CHAR
                             && held[1] != upd_pkg::THREE_CHAR) begin
                    abort_string(upd_pkg::ST_NO_UTF8, last);
                end else begin
                    v = {hi, lo};
                    if (held[1] == upd_pkg::THREE_CHAR) begin
                        v = v | upd_pkg::FOLD_BITS;
                    end
                    esc_phase = upd_pkg::PH_IDLE;
                    two_byte  = 1'b0;
                    add_decoded(v, upd_pkg::ST_BYTE, last);
                end
            end
            default: begin
                esc_phase = upd_pkg::PH_IDLE;
                two_byte  = 1'b0;
                if (c == upd_pkg::PCT_CHAR) begin
                    if (last) begin
                        abort_string(upd_pkg::ST_NEED, last);
                    end else begin
                        esc_phase = upd_pkg::PH_C1;
                    end
                end else begin
                    add_decoded(c, upd_pkg::ST_BYTE, last);
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_decoded want;
        if (!i_rst_n) begin
            esc_phase = upd_pkg::PH_IDLE;
            two_byte  = 1'b0;
            skipping  = 1'b0;
            lazy      = 1'b0;
            decoded_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == LAZY_ADDR) begin
                lazy = i_pwdata[0];
            end
            if (i_in_valid && !i_in_stall) begin
                decode_char(i_in_char, i_in_last);
            end
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result: byte %h status %0d last %b",
                             $time, i_out_byte, i_status, i_out_last);
                    mismatch_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (want.data !== i_out_byte || want.status !== i_status
                            || want.last !== i_out_last) begin
                        $display("%0t: mismatch: expected byte %h status %0d last %b, %s",
                                 $time, want.data, want.status, want.last, "got");
                        $display("%0t:           actual   byte %h status %0d last %b",
                                 $time, i_out_byte, i_status, i_out_last);
                        mismatch_count++;
                    end
                end
            end
        end
        o_pending    <= decoded_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

>>> tb/tb_url_percent_decoder.sv
// top of the url percent decoder testbench: clock, reset, register writes and request
// stimulus with random idling; checking is done by upd_checker; depends on upd_pkg
`timescale 1ns / 100ps

module tb_url_percent_decoder;

    localparam logic [2:0] LAZY_ADDR        = 3'd0;  // lazy_mode register
    localparam int         LONG_HOLD_CYCLES = 200;   // receiver hold-off, fills the queue
    localparam int         SETTLE_CYCLES    = 4;     // extra wait to let the pipe settle
    localparam int         PHASE_CHARS      = 100;   // requests per random phase

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  in_char    = 8'h00;
    logic        in_last    = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  out_byte;
    logic [1:0]  out_status;
    logic        out_last;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = 3'd0;
    logic [31:0] pwdata     = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;

    // shared knobs between the sender and the receiver process
    bit          idle_on    = 1'b0;   // random gaps and stalls
    bit          long_hold  = 1'b0;   // receiver holds off for a long stretch
    int          chars_accepted = 0;
    logic [7:0]  string_chars[$];     // encoded string under construction

    always #10 clk = ~clk;

    url_percent_decoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_char   (in_char),
        .i_in_last   (in_last),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_byte  (out_byte),
        .o_status    (out_status),
        .o_out_last  (out_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    upd_checker #(
        .LAZY_ADDR (LAZY_ADDR)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_char    (in_char),
        .i_in_last    (in_last),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_byte   (out_byte),
        .i_status     (out_status),
        .i_out_last   (out_last),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // random hex digit, either case for letters
    function automatic logic [7:0] rand_hex();
        int unsigned n;
        n = $urandom_range(0, 21);
        if (n < 10) begin
            return 8'(32'h30 + n);
        end else if (n < 16) begin
            return 8'(32'h41 + n - 10);
        end
        return 8'(32'h61 + n - 16);
    endfunction

    // mostly hex, sometimes anything, to hit the bad hex checks
    function automatic logic [7:0] maybe_hex();
        if ($urandom_range(0, 3) == 0) begin
            return rand_byte();
        end
        return rand_hex();
    endfunction

    task automatic add_char(input logic [7:0] c);
        string_chars.insert(string_chars.size(), c);
    endtask

    // one request; valid stays high across back-to-back requests, the payload
    // only moves after the accepting edge
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        in_last  <= last;
        do @(posedge clk); while (in_stall);
        chars_accepted++;
    endtask

    task automatic send_text(input string text, input logic last_at_end);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i], last_at_end && i == text.len() - 1);
        end
    endtask

    task automatic send_string();
        for (int i = 0; i < string_chars.size(); i++) begin
            send_char(string_chars[i], i == string_chars.size() - 1);
        end
    endtask

    // build one encoded string out of a few random tokens
    task automatic build_string();
        int tokens;
        int kind;
        int extra;
        string_chars.delete();
        tokens = $urandom_range(1, 6);
        repeat (tokens) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    // plain character
                    add_char(rand_byte());
                end
                4, 5: begin
                    // well-formed single escape
                    add_char(upd_pkg::PCT_CHAR);
                    add_char(rand_hex());
                    add_char(rand_hex());
                end
                6, 7: begin
                    // well-formed two-byte escape, separator usually a percent
                    add_char(upd_pkg::PCT_CHAR);
                    add_char(upd_pkg::C_CHAR);
                    add_char($urandom_range(0, 1) ? upd_pkg::THREE_CHAR : upd_pkg::TWO_CHAR);
                    add_char($urandom_range(0, 3) != 0 ? upd_pkg::PCT_CHAR : rand_byte());
                    add_char(rand_hex());
                    add_char(rand_hex());
                end
                8: begin
                    // broken two-byte escape: odd selector digit, lower case c, bad hex
                    add_char(upd_pkg::PCT_CHAR);
                    add_char($urandom_range(0, 3) == 0 ? 8'h63 : upd_pkg::C_CHAR);
                    add_char(maybe_hex());
                    add_char(rand_byte());
                    add_char(maybe_hex());
                    add_char(maybe_hex());
                end
                default: begin
                    // percent plus noise, often cut short
                    add_char(upd_pkg::PCT_CHAR);
                    extra = $urandom_range(0, 2);
                    repeat (extra) add_char(rand_byte());
                end
            endcase
        end
    endtask

    // setup cycle then access cycle; the register takes the data when pready is seen
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sender pauses until every decoded result is out, then lets the pipe settle
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver: random stall per result, plus one long hold-off on request
    initial begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end else if (idle_on) begin
                hold = $urandom_range(0, 3);
                if (hold > 0) begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // run limit, far above the slowest legal run
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int phase;
        int target;
        logic lazy_bit;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(LAZY_ADDR, 32'd0);

        // directed strings, strict mode, no idling
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("%C3%a1", 1'b0);     // folded two-byte escape
        send_text("%c3", 1'b0);        // lower case c decodes plainly
        send_text("%C5%41zq", 1'b1);   // selector not 2/3, rest of string swallowed
        send_text("%g1", 1'b1);        // bad hex on the last char, no skipping after
        send_text("%C", 1'b1);         // string ends inside the escape

        // random phases alternate the mode; one phase runs without idling and one
        // holds the receiver off while the sender keeps going
        for (phase = 0; phase < 6; phase++) begin
            wait_quiet();
            lazy_bit = (phase % 2 == 0);
            write_reg(LAZY_ADDR, ($urandom & 32'hFFFF_FFFE) | {31'd0, lazy_bit});
            idle_on = (phase != 3);
            if (phase == 2) begin
                long_hold = 1'b1;
            end
            target = chars_accepted + PHASE_CHARS;
            while (chars_accepted < target) begin
                build_string();
                send_string();
            end
        end

        // drain and give the verdict
        wait_quiet();
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
